@@ rtl/loose_octree_node_placement_assert.svh @@
// Assertion macros for the loose octree placement block.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef LOOSE_OCTREE_NODE_PLACEMENT_ASSERT_SVH
`define LOOSE_OCTREE_NODE_PLACEMENT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define LONP_AST_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define LONP_AST_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ rtl/lonp_pkg.sv @@
// Types, codes and path helpers for the loose octree placement block.
// No dependencies.
`timescale 1ns / 1ps

package lonp_pkg;

  localparam int MAX_LEVELS = 8;
  localparam int LVL_W      = 3;
  localparam int PATH_W     = 21;
  localparam int DW         = 35;   // signed offset pos - centre
  localparam int HW_W       = 31;
  localparam int LOOSE_W    = 14;
  localparam int PROD_W     = HW_W + LOOSE_W;
  localparam int FRAC_W     = 12;   // Q2.12 looseness
  localparam int NUM_OCT    = MAX_LEVELS - 1;

  localparam logic [LOOSE_W-1:0] LOOSE_ONE = 14'd4096;

  typedef struct packed {
    logic                     kind;
    logic signed [31:0]       pos_x;
    logic signed [31:0]       pos_y;
    logic signed [31:0]       pos_z;
    logic [30:0]              radius;
    logic [LVL_W-1:0]         from_level;
    logic [PATH_W-1:0]        from_path;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0]         node_level;
    logic [PATH_W-1:0]        node_path;
    logic                     stopped_by_straddle;
    logic [LVL_W-1:0]         levels_climbed;
  } out_item_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_WALK  = 7'b0000010,
    ST_LIM   = 7'b0000100,
    ST_CLIMB = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_THR   = 7'b0100000,
    ST_TEST  = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    REG_ROOT_X  = 3'd0,
    REG_ROOT_Y  = 3'd1,
    REG_ROOT_Z  = 3'd2,
    REG_ROOT_HW = 3'd3,
    REG_LOOSE   = 3'd4,
    REG_LEVELS  = 3'd5
  } reg_idx_t;

  localparam logic KIND_UPDATE = 1'b1;

  // Ones in the path chunks of all levels below lvl.
  function automatic logic [PATH_W-1:0] low_mask(input logic [LVL_W-1:0] lvl);
    logic [PATH_W-1:0] m;
    m = '0;
    for (int i = 0; i < NUM_OCT; i++) begin
      if (LVL_W'(i) < lvl) m[3*i +: 3] = 3'b111;
    end
    return m;
  endfunction

  function automatic logic [2:0] get_octant(input logic [PATH_W-1:0] path,
                                            input logic [LVL_W-1:0] idx);
    logic [2:0] o;
    o = 3'b000;
    for (int i = 0; i < NUM_OCT; i++) begin
      if (idx == LVL_W'(i)) o = path[3*i +: 3];
    end
    return o;
  endfunction

  function automatic logic [PATH_W-1:0] set_octant(input logic [PATH_W-1:0] path,
                                                   input logic [LVL_W-1:0] idx,
                                                   input logic [2:0] oct);
    logic [PATH_W-1:0] p;
    p = path;
    for (int i = 0; i < NUM_OCT; i++) begin
      if (idx == LVL_W'(i)) p[3*i +: 3] = oct;
    end
    return p;
  endfunction

endpackage

@@ rtl/loose_octree_node_placement.sv @@
// Loose octree node placement: top level with APB register file and sequencer.
// Depends on lonp_pkg and loose_octree_node_placement_assert.svh.
`timescale 1ns / 1ps
`include "loose_octree_node_placement_assert.svh"

// Places one sphere per transaction into a full loose octree and returns the
// node level, octal path, whether a straddle stopped the descent, and how many
// levels an update climbed. One transaction is worked at a time; in_stall is
// high from acceptance until the result is loaded into the output register.
// From acceptance the block walks down to the start level (0 for an insert),
// makes the climb tests of an update, then visits the nodes on the way down,
// each through the multiply, threshold and test steps.
// Each pass is one tree level through a shared three-lane offset adder and
// window compare, with one 31x14 multiplier for the loose extension; the
// output register frees the block while a result waits to be taken.
// Registers sit at byte addresses 4*i: root centre x, y, z, root half width,
// looseness (Q2.12) and levels in use.
module loose_octree_node_placement
  import lonp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic signed [31:0]  root_x_r, root_y_r, root_z_r;
  logic [HW_W-1:0]     root_hw_r;
  logic [LOOSE_W-1:0]  loose_r;
  logic [3:0]          levels_r;

  logic                cfg_wr;
  logic [3:0]          levels_eff;
  logic [LVL_W-1:0]    deepest;
  logic [LOOSE_W-1:0]  excess;

  // sequencer and datapath
  state_t              state_r, state_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [LVL_W-1:0]    tgt_r, tgt_nxt;
  logic [LVL_W-1:0]    climbed_r, climbed_nxt;
  logic                kind_r, kind_nxt;
  logic [PATH_W-1:0]   path_r, path_nxt;
  logic [30:0]         rad_r, rad_nxt;
  logic signed [DW-1:0] d_r [3];
  logic signed [DW-1:0] d_nxt [3];
  logic signed [DW-1:0] thr_hi_r, thr_hi_nxt;
  logic signed [DW-1:0] thr_lo_r, thr_lo_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                in_acc;
  logic                out_free;
  logic [3:0]          sh_amt;
  logic [HW_W-1:0]     shifted;
  logic signed [DW-1:0] step_s;
  logic signed [DW-1:0] rad_s;
  logic [2:0]          oct_bits;
  logic [2:0]          in_win;
  logic [2:0]          child;
  logic                straddle;
  logic [LVL_W-1:0]    start_lvl;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_x_r  <= '0;
      root_y_r  <= '0;
      root_z_r  <= '0;
      root_hw_r <= 31'd65536;
      loose_r   <= 14'd8192;
      levels_r  <= 4'd8;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_ROOT_X:  root_x_r  <= cfg_pwdata;
        REG_ROOT_Y:  root_y_r  <= cfg_pwdata;
        REG_ROOT_Z:  root_z_r  <= cfg_pwdata;
        REG_ROOT_HW: root_hw_r <= cfg_pwdata[HW_W-1:0];
        REG_LOOSE:   loose_r   <= cfg_pwdata[LOOSE_W-1:0];
        REG_LEVELS:  levels_r  <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_ROOT_X:  cfg_prdata = root_x_r;
      REG_ROOT_Y:  cfg_prdata = root_y_r;
      REG_ROOT_Z:  cfg_prdata = root_z_r;
      REG_ROOT_HW: cfg_prdata = 32'(root_hw_r);
      REG_LOOSE:   cfg_prdata = 32'(loose_r);
      REG_LEVELS:  cfg_prdata = 32'(levels_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // clamp depth to 1..MAX_LEVELS
  always_comb begin
    if (levels_r == 4'd0)                     levels_eff = 4'd1;
    else if (levels_r > 4'(MAX_LEVELS))       levels_eff = 4'(MAX_LEVELS);
    else                                      levels_eff = levels_r;
    deepest = LVL_W'(levels_eff - 4'd1);
  end

  assign excess = (loose_r > LOOSE_ONE) ? (loose_r - LOOSE_ONE) : '0;

  // ---------------- shared datapath ----------------
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // walk and descent move one level down, the rest work on the current level
  assign sh_amt  = {1'b0, lvl_r} + (((state_r == ST_WALK) || (state_r == ST_TEST)) ?
                                    4'd1 : 4'd0);
  assign shifted = root_hw_r >> sh_amt;
  assign step_s  = $signed(DW'(shifted));
  assign rad_s   = $signed(DW'(rad_r));

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      in_win[a] = (d_r[a] >= thr_lo_r) && (d_r[a] <= thr_hi_r);
      child[a]  = ~d_r[a][DW-1] && (d_r[a] != '0);
    end
  end
  assign straddle = |in_win;

  always_comb begin
    case (state_r)
      ST_WALK:  oct_bits = get_octant(path_r, lvl_r);
      ST_CLIMB: oct_bits = get_octant(path_r, lvl_r - 3'd1);
      default:  oct_bits = child;
    endcase
  end

  assign start_lvl = (in_data.kind == KIND_UPDATE) ?
                     ((in_data.from_level > deepest) ? deepest : in_data.from_level) : '0;

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    tgt_nxt       = tgt_r;
    climbed_nxt   = climbed_r;
    kind_nxt      = kind_r;
    path_nxt      = path_r;
    rad_nxt       = rad_r;
    thr_hi_nxt    = thr_hi_r;
    thr_lo_nxt    = thr_lo_r;
    prod_nxt      = prod_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;
    for (int a = 0; a < 3; a++) d_nxt[a] = d_r[a];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          kind_nxt    = in_data.kind;
          rad_nxt     = in_data.radius;
          tgt_nxt     = start_lvl;
          path_nxt    = in_data.from_path & low_mask(start_lvl);
          lvl_nxt     = '0;
          climbed_nxt = '0;
          d_nxt[0]    = DW'(in_data.pos_x) - DW'(root_x_r);
          d_nxt[1]    = DW'(in_data.pos_y) - DW'(root_y_r);
          d_nxt[2]    = DW'(in_data.pos_z) - DW'(root_z_r);
          state_nxt   = ST_WALK;
        end
      end
      ST_WALK: begin
        // move the centre down the given path to the start node
        if (lvl_r == tgt_r) begin
          state_nxt = ((kind_r == KIND_UPDATE) && (lvl_r != '0)) ? ST_LIM : ST_MUL;
        end else begin
          for (int a = 0; a < 3; a++)
            d_nxt[a] = oct_bits[a] ? (d_r[a] - step_s) : (d_r[a] + step_s);
          lvl_nxt = lvl_r + 3'd1;
        end
      end
      ST_LIM: begin
        thr_hi_nxt = step_s - rad_s;
        thr_lo_nxt = rad_s - step_s;
        state_nxt  = ST_CLIMB;
      end
      ST_CLIMB: begin
        if (&in_win) begin
          state_nxt = ST_MUL;
        end else begin
          // back out the octant of the level above
          for (int a = 0; a < 3; a++)
            d_nxt[a] = oct_bits[a] ? (d_r[a] + step_s) : (d_r[a] - step_s);
          path_nxt    = path_r & low_mask(lvl_r - 3'd1);
          lvl_nxt     = lvl_r - 3'd1;
          climbed_nxt = climbed_r + 3'd1;
          state_nxt   = (lvl_r == 3'd1) ? ST_MUL : ST_LIM;
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(shifted) * PROD_W'(excess);
        state_nxt = ST_THR;
      end
      ST_THR: begin
        thr_hi_nxt = rad_s - DW'(prod_r[PROD_W-1:FRAC_W]);
        thr_lo_nxt = DW'(prod_r[PROD_W-1:FRAC_W]) - rad_s;
        state_nxt  = ST_TEST;
      end
      ST_TEST: begin
        if (straddle || (lvl_r >= deepest)) begin
          // hold here until the output register frees
          if (out_free) begin
            out_data_nxt.node_level          = lvl_r;
            out_data_nxt.node_path           = path_r;
            out_data_nxt.stopped_by_straddle = straddle;
            out_data_nxt.levels_climbed      = climbed_r;
            out_valid_nxt                    = 1'b1;
            state_nxt                        = ST_IDLE;
          end
        end else begin
          for (int a = 0; a < 3; a++)
            d_nxt[a] = oct_bits[a] ? (d_r[a] - step_s) : (d_r[a] + step_s);
          path_nxt  = set_octant(path_r, lvl_r, child);
          lvl_nxt   = lvl_r + 3'd1;
          state_nxt = ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    tgt_r      <= tgt_nxt;
    climbed_r  <= climbed_nxt;
    kind_r     <= kind_nxt;
    path_r     <= path_nxt;
    rad_r      <= rad_nxt;
    d_r        <= d_nxt;
    thr_hi_r   <= thr_hi_nxt;
    thr_lo_r   <= thr_lo_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  // ---------------- assertions ----------------
  `LONP_AST_NXT(a_busy_after_accept, in_acc, in_stall, "accepted transaction did not start")
  `LONP_AST_IMP(a_path_clean, out_valid_r, (out_data_r.node_path & ~low_mask(out_data_r.node_level)) == '0, "path bits above result level")
  `LONP_AST_IMP(a_level_depth, out_valid_r, out_data_r.node_level <= deepest, "result below deepest level")
  `LONP_AST_IMP(a_test_depth, state_r == ST_TEST, lvl_r <= deepest, "descent past deepest level")
  `LONP_AST_IMP(a_climb_update, state_r == ST_LIM, (kind_r == KIND_UPDATE) && (lvl_r != '0), "climb outside an update")

endmodule
